// ===== design/fab_pkg.sv =====
// ----------------------------------------------------------------------------
// fab_pkg
// shared types, widths and codes of the frame animation timer
// ----------------------------------------------------------------------------
package fab_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int IDX_W      = $clog2(MAX_FRAMES);
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
    localparam int DUR_W      = 16;
    localparam int TOT_W      = DUR_W + IDX_W;
    localparam int ELAP_W     = 32;
    localparam int DIV_CNT_W  = $clog2(ELAP_W);
    localparam int STEP_W     = 10;
    localparam int FCNT_W     = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [1:0] t_op;

    localparam t_op OP_TICK    = 2'd0;
    localparam t_op OP_LOAD    = 2'd1;
    localparam t_op OP_RESTART = 2'd2;
    localparam t_op OP_STOP    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_STEP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP        = 3'd3;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] idx;
        logic [DUR_W-1:0] dur;
        logic             arm;
    } t_cmd;

    typedef struct packed {
        logic [STEP_W-1:0] tick_step;
        logic [FCNT_W-1:0] frame_count;
        logic              reverse;
        logic              loop;
    } t_cfg;

endpackage

// ===== design/fab_front.sv =====
// ----------------------------------------------------------------------------
// fab_front
// command intake: accepts a word and classifies it into a queue entry
// ----------------------------------------------------------------------------
module fab_front import fab_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  t_op              i_operation,
    input  logic [IDX_W-1:0] i_frame_index,
    input  logic [DUR_W-1:0] i_duration_ms,
    input  logic             i_arm_notice,
    input  logic             i_full,
    output logic             busy,
    output logic             o_push,
    output t_cmd             o_cmd
);

    logic r_rst_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rst_done <= 1'b0;
        end else begin
            r_rst_done <= 1'b1;
        end
    end

    assign busy   = i_full | ~r_rst_done;
    assign o_push = start & ~busy;

    always_comb begin
        o_cmd     = '0;
        o_cmd.op  = i_operation;
        unique case (i_operation)
            OP_LOAD: begin
                o_cmd.idx = i_frame_index;
                o_cmd.dur = i_duration_ms;
            end
            OP_RESTART: begin
                o_cmd.arm = i_arm_notice;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== design/fab_queue.sv =====
// ----------------------------------------------------------------------------
// fab_queue
// two-entry command queue between intake and execution
// ----------------------------------------------------------------------------
module fab_queue import fab_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rd];
    assign w_push  = i_push & ~o_full;
    assign w_pop   = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

// ===== design/fab_back.sv =====
// ----------------------------------------------------------------------------
// fab_back
// command execution: timer state, duration table, total sum, modulo, frame walk
// ----------------------------------------------------------------------------
module fab_back import fab_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_empty,
    input  t_cmd             i_cmd,
    output logic             o_pop,
    output logic             o_strobe,
    output logic [IDX_W-1:0] o_current_frame,
    output logic             o_done_res,
    output logic             o_notice,
    output logic             o_running
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SUM   = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_FRAME = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_WALK  = 3'd6;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(ELAP_W - 1);

    logic [2:0]           r_state, n_state;
    t_cmd                 r_cmd, n_cmd;
    logic [ELAP_W-1:0]    r_elapsed, n_elapsed;
    logic                 r_run, n_run;
    logic                 r_armed, n_armed;
    logic [DUR_W-1:0]     r_table [MAX_FRAMES];
    logic [TOT_W-1:0]     r_total, n_total;
    logic [IDX_W-1:0]     r_frame, n_frame;
    logic [IDX_W-1:0]     r_cnt, n_cnt;
    logic                 r_fired, n_fired;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;
    logic [ELAP_W-1:0]    r_dvd, n_dvd;
    logic [TOT_W-1:0]     r_rem, n_rem;
    logic                 r_div_note, n_div_note;
    logic                 r_strobe, n_strobe;

    logic [FCNT_W-1:0]    w_n;
    logic [IDX_W-1:0]     w_last;
    logic [DUR_W-1:0]     w_d;
    logic                 w_done;
    logic [TOT_W:0]       w_trial;
    logic                 w_trial_ge;
    logic [TOT_W-1:0]     w_rem_next;
    logic                 w_walk_ge;
    logic                 w_tbl_we;

    always_comb begin
        w_n = i_cfg.frame_count;
        if (w_n == '0) begin
            w_n = FCNT_W'(1);
        end else if (w_n > FCNT_W'(MAX_FRAMES)) begin
            w_n = FCNT_W'(MAX_FRAMES);
        end
    end

    assign w_last     = IDX_W'(w_n - FCNT_W'(1));
    assign w_d        = r_table[r_frame];
    assign w_done     = (r_elapsed >= ELAP_W'(r_total));
    assign w_trial    = {r_rem, r_dvd[ELAP_W-1]};
    assign w_trial_ge = (w_trial >= {1'b0, r_total});
    assign w_rem_next = w_trial_ge ? TOT_W'(w_trial - {1'b0, r_total}) : w_trial[TOT_W-1:0];
    assign w_walk_ge  = (r_rem >= TOT_W'(w_d));
    assign w_tbl_we   = (r_state == S_EXEC) && (r_cmd.op == OP_LOAD);

    assign o_pop           = (r_state == S_IDLE) && !i_empty;
    assign o_strobe        = r_strobe;
    assign o_current_frame = r_frame;
    assign o_done_res      = r_done;
    assign o_notice        = r_fired;
    assign o_running       = r_run;

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_elapsed  = r_elapsed;
        n_run      = r_run;
        n_armed    = r_armed;
        n_total    = r_total;
        n_frame    = r_frame;
        n_cnt      = r_cnt;
        n_fired    = r_fired;
        n_done     = r_done;
        n_div_cnt  = r_div_cnt;
        n_dvd      = r_dvd;
        n_rem      = r_rem;
        n_div_note = r_div_note;
        n_strobe   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_cmd   = i_cmd;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_fired = 1'b0;
                n_frame = '0;
                n_total = '0;
                unique case (r_cmd.op)
                    OP_TICK: begin
                        if (r_run) begin
                            n_elapsed = r_elapsed + ELAP_W'(i_cfg.tick_step);
                        end
                    end
                    OP_RESTART: begin
                        n_armed   = r_cmd.arm;
                        n_elapsed = '0;
                        n_run     = 1'b1;
                    end
                    OP_STOP: begin
                        n_run = 1'b0;
                    end
                    default: begin
                    end
                endcase
                n_state = S_SUM;
            end
            S_SUM: begin
                n_total = r_total + TOT_W'(w_d);
                n_frame = r_frame + IDX_W'(1);
                if (r_frame == w_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_FRAME;
                if (r_cmd.op == OP_TICK && r_run && r_armed && w_done) begin
                    n_fired = 1'b1;
                    n_armed = 1'b0;
                    if (r_total == '0) begin
                        n_elapsed = '0;
                    end else begin
                        n_dvd      = r_elapsed;
                        n_rem      = '0;
                        n_div_cnt  = '0;
                        n_div_note = 1'b1;
                        n_state    = S_DIV;
                    end
                end
            end
            S_FRAME: begin
                n_done = w_done;
                if (!i_cfg.loop && w_done) begin
                    n_frame  = w_last;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else if (r_total == '0) begin
                    n_frame  = '0;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else if (w_done) begin
                    n_dvd      = r_elapsed;
                    n_rem      = '0;
                    n_div_cnt  = '0;
                    n_div_note = 1'b0;
                    n_state    = S_DIV;
                end else begin
                    n_rem   = r_elapsed[TOT_W-1:0];
                    n_frame = i_cfg.reverse ? w_last : '0;
                    n_cnt   = '0;
                    n_state = S_WALK;
                end
            end
            S_DIV: begin
                n_rem     = w_rem_next;
                n_dvd     = {r_dvd[ELAP_W-2:0], 1'b0};
                n_div_cnt = r_div_cnt + DIV_CNT_W'(1);
                if (r_div_cnt == DIV_LAST) begin
                    if (r_div_note) begin
                        n_elapsed = ELAP_W'(w_rem_next);
                        n_state   = S_FRAME;
                    end else begin
                        n_frame = i_cfg.reverse ? w_last : '0;
                        n_cnt   = '0;
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (w_walk_ge) begin
                    n_rem   = r_rem - TOT_W'(w_d);
                    n_frame = i_cfg.reverse ? r_frame - IDX_W'(1) : r_frame + IDX_W'(1);
                    n_cnt   = r_cnt + IDX_W'(1);
                    if (r_cnt == w_last) begin
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_elapsed <= '0;
            r_run     <= 1'b0;
            r_armed   <= 1'b0;
            r_strobe  <= 1'b0;
            r_fired   <= 1'b0;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_table[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_elapsed <= n_elapsed;
            r_run     <= n_run;
            r_armed   <= n_armed;
            r_strobe  <= n_strobe;
            r_fired   <= n_fired;
            if (w_tbl_we) begin
                r_table[r_cmd.idx] <= r_cmd.dur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_total    <= n_total;
        r_frame    <= n_frame;
        r_cnt      <= n_cnt;
        r_done     <= n_done;
        r_div_cnt  <= n_div_cnt;
        r_dvd      <= n_dvd;
        r_rem      <= n_rem;
        r_div_note <= n_div_note;
    end

endmodule

// ===== design/frame_animation_timer.sv =====
// ----------------------------------------------------------------------------
// frame_animation_timer
// frame sequencer for one animation with a duration table and completion notice
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; up to two words
// queue ahead of execution. Each word gives exactly one result, shown for one
// cycle with o_strobe; the receiver cannot stall it. Execution forms the total
// sum over the N frames in use, then may run a bit-serial modulo of the elapsed
// time (at most one per word, when looping past the end or on the notice),
// then a frame walk over up to N frames; the result word is registered.
// Busy is also high for the first cycle after reset. Configuration writes are
// always ready; they are to apply while idle, so the user must write them only
// while idle; the block itself does not enforce this.
module frame_animation_timer import fab_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_operation,
    input  logic [IDX_W-1:0]      i_frame_index,
    input  logic [DUR_W-1:0]      i_duration_ms,
    input  logic                  i_arm_notice,
    output logic                  o_strobe,
    output logic [IDX_W-1:0]      o_current_frame,
    output logic                  o_done_res,
    output logic                  o_notice,
    output logic                  o_running,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    logic w_full;
    logic w_empty;
    logic w_push;
    logic w_pop;
    t_cmd w_front_cmd;
    t_cmd w_back_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tick_step   <= STEP_W'(16);
            r_cfg.frame_count <= FCNT_W'(1);
            r_cfg.reverse     <= 1'b0;
            r_cfg.loop        <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TICK_STEP:   r_cfg.tick_step   <= i_cfg_data[STEP_W-1:0];
                CFG_FRAME_COUNT: r_cfg.frame_count <= i_cfg_data[FCNT_W-1:0];
                CFG_REVERSE:     r_cfg.reverse     <= i_cfg_data[0];
                CFG_LOOP:        r_cfg.loop        <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    fab_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .i_operation   (i_operation),
        .i_frame_index (i_frame_index),
        .i_duration_ms (i_duration_ms),
        .i_arm_notice  (i_arm_notice),
        .i_full        (w_full),
        .busy          (busy),
        .o_push        (w_push),
        .o_cmd         (w_front_cmd)
    );

    fab_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_cmd   (w_back_cmd)
    );

    fab_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_empty         (w_empty),
        .i_cmd           (w_back_cmd),
        .o_pop           (w_pop),
        .o_strobe        (o_strobe),
        .o_current_frame (o_current_frame),
        .o_done_res      (o_done_res),
        .o_notice        (o_notice),
        .o_running       (o_running)
    );

endmodule
